// ===== hdl/pwbr_pkg.sv =====
package pwbr_pkg;

  localparam int unsigned EdgeTimeW = 16;
  localparam int unsigned ThreshW   = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxBytes   = 8'd1;

  localparam logic [ThreshW-1:0] HalfPeriodRst = 16'd0;
  localparam logic [ByteW-1:0]   MaxBytesRst   = 8'd1;

  typedef struct packed {
    logic [EdgeTimeW-1:0] edge_time;
    logic                 new_transfer;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic [ThreshW-1:0] half_period_ticks;
    logic [ByteW-1:0]   max_bytes;
  } cfg_t;

endpackage

// ===== hdl/pwbr_stream_if.sv =====
interface pwbr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/pwbr_decoder.sv =====
module pwbr_decoder #(
  parameter int unsigned STAMP_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pwbr_pkg::in_item_t item_i,
  input  pwbr_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output pwbr_pkg::out_item_t res_o
);
  import pwbr_pkg::*;

  logic [STAMP_BITS-1:0] falling_q, falling_d;
  logic                  second_q, second_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [ByteW-1:0]      shift_q, shift_d;
  logic [ByteW-1:0]      done_q, done_d;
  logic                  finished_q, finished_d;

  logic [31:0]           stamp_ext;
  logic [STAMP_BITS-1:0] stamp;
  logic [STAMP_BITS-1:0] low_time;
  logic                  fin_eff, sec_eff;
  logic [2:0]            cnt_eff, cnt_inc;
  logic [ByteW-1:0]      shift_eff, shift_nxt, done_eff, last_idx;
  logic                  is_last;

  assign stamp_ext = 32'(item_i.edge_time);
  assign stamp     = stamp_ext[STAMP_BITS-1:0];
  assign low_time  = stamp - falling_q;

  // new transfer clears pairing and count before this edge is handled
  assign fin_eff   = item_i.new_transfer ? 1'b0 : finished_q;
  assign sec_eff   = item_i.new_transfer ? 1'b0 : second_q;
  assign cnt_eff   = item_i.new_transfer ? 3'd0 : cnt_q;
  assign shift_eff = item_i.new_transfer ? '0 : shift_q;
  assign done_eff  = item_i.new_transfer ? '0 : done_q;

  assign cnt_inc   = cnt_eff + 3'd1;
  assign shift_nxt = {shift_eff[ByteW-2:0], (32'(low_time) < 32'(cfg_i.half_period_ticks))};
  assign last_idx  = cfg_i.max_bytes - 8'd1;
  assign is_last   = (done_eff == last_idx);

  always_comb begin
    falling_d   = falling_q;
    second_d    = sec_eff;
    cnt_d       = cnt_eff;
    shift_d     = shift_eff;
    done_d      = done_eff;
    finished_d  = fin_eff;
    res_valid_o = 1'b0;
    res_o.data_byte  = shift_nxt;
    res_o.byte_index = done_eff;
    res_o.last       = is_last;
    if (!fin_eff) begin
      if (!sec_eff) begin
        falling_d = stamp;
        second_d  = 1'b1;
      end else begin
        second_d = 1'b0;
        cnt_d    = cnt_inc;
        if (cnt_inc == 3'd0) begin
          res_valid_o = step_i;
          done_d      = done_eff + 8'd1;
          shift_d     = '0;
          finished_d  = is_last;
        end else begin
          shift_d = shift_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      falling_q  <= '0;
      second_q   <= 1'b0;
      cnt_q      <= 3'd0;
      shift_q    <= '0;
      done_q     <= '0;
      finished_q <= 1'b1;
    end else if (step_i) begin
      falling_q  <= falling_d;
      second_q   <= second_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      done_q     <= done_d;
      finished_q <= finished_d;
    end
  end

endmodule

// ===== hdl/pulse_width_byte_receiver.sv =====
// Pulse-width byte receiver. Edge stamps arrive on in_i as falling/rising pairs; each pair's
// low time (modulo 2^STAMP_BITS) is compared against half_period_ticks, shorter meaning a one,
// and eight bits form a byte, first bit in the MSB. A byte leaves on out_o with its index, the
// byte at index max_bytes-1 is flagged last and later edges are dropped until an item with
// new_transfer set. One edge is taken per clock; an edge passes through the input register,
// then the decode step loads the result register. A stalled result holds out_o and lets one
// more edge wait in the input register before in_i drops ready.
// Configuration writes on cfg_i are always accepted and are meant for idle periods only.
module pulse_width_byte_receiver #(
  parameter int unsigned STAMP_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pwbr_stream_if.sink  cfg_i,
  pwbr_stream_if.sink  in_i,
  pwbr_stream_if.source out_o
);
  import pwbr_pkg::*;

  cfg_t      cfg_q;
  logic      inq_valid_q;
  in_item_t  inq_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;

  logic      step;
  logic      res_valid;
  out_item_t res;
  cfg_req_t  cfg_req;
  in_item_t  in_item;

  assign cfg_req = cfg_i.data;
  assign in_item = in_i.data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HalfPeriodRst;
      cfg_q.max_bytes         <= MaxBytesRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_req.index)
        CfgHalfPeriod: cfg_q.half_period_ticks <= cfg_req.value;
        CfgMaxBytes:   cfg_q.max_bytes         <= cfg_req.value[ByteW-1:0];
        default:       ;
      endcase
    end
  end

  // decode step only when the result register can take whatever it yields
  assign step       = inq_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !inq_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      inq_data_q <= in_item;
    end
  end

  pwbr_decoder #(
    .STAMP_BITS (STAMP_BITS)
  ) u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (inq_data_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== hdl/pwbr_checker.sv =====
module pwbr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input pwbr_pkg::out_item_t out_data_i
);
  import pwbr_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // a waiting result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // input only backs up behind a full, stalled result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  // a new result comes from an edge taken earlier, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer, 2))
    else $error("result without a preceding input transfer");

endmodule

bind pulse_width_byte_receiver pwbr_checker u_pwbr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
